### design/bmhq_pkg.sv
package bmhq_pkg;

    // heap geometry
    localparam int CAPACITY = 64;
    localparam int DEPTH    = CAPACITY + 1;        // slot 0 unused, heap is 1-based
    localparam int ADDR_W   = $clog2(CAPACITY + 1);
    localparam int CNT_W    = ADDR_W;
    localparam int DATA_W   = 32;

    // command codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_LAST,
        S_POP_RD,
        S_POP_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] top_value;
        logic [CNT_W-1:0]         entry_total;
        logic [1:0]               status;
    } t_result;

    // RAM control from the sequencer
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr_a;
        logic [ADDR_W-1:0]        raddr_b;
    } t_ram_ctl;

endpackage

### design/bmhq_cmd_if.sv
interface bmhq_cmd_if import bmhq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

### design/bmhq_res_if.sv
interface bmhq_res_if import bmhq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic [CNT_W-1:0]         entry_total;
    logic [1:0]               status;

    modport source (output valid, output removed_value, output top_value,
                    output entry_total, output status, input ready);
    modport sink   (input valid, input removed_value, input top_value,
                    input entry_total, input status, output ready);
endinterface

### design/binary_min_heap_queue.sv
// Channel  Dir  Payload                                           Handshake
// i_cmd    in   command[1:0], value[31:0] signed                  valid/ready
// o_res    out  removed_value, top_value, entry_total[6:0], status valid/ready
//
// One command at a time, counted accept to accept. A push alternates a RAM read and a
// compare per level climbed, stopping at the root or once the parent is not greater;
// a pop reads the last entry, then alternates a read and a compare per level
// descended. Clear, no-op, full and empty cases go straight to the result. Synchronous
// active-low reset empties the heap, RAM is not cleared. A waiting result does not
// block the next command; the sequencer holds only when the output word is also full.
module binary_min_heap_queue import bmhq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmhq_cmd_if.sink   i_cmd,
    bmhq_res_if.source o_res
);

    t_cmd_word                cmd_word;
    t_result                  seq_res;
    t_ram_ctl                 ram_ctl;
    logic                     seq_res_valid;
    logic                     out_free;
    logic signed [DATA_W-1:0] rdata_a;
    logic signed [DATA_W-1:0] rdata_b;

    logic                     r_out_valid;
    t_result                  r_out;

    assign cmd_word.command = i_cmd.command;
    assign cmd_word.value   = i_cmd.value;
    assign out_free         = !r_out_valid || o_res.ready;

    bmhq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .i_cmd       (cmd_word),
        .o_res_valid (seq_res_valid),
        .i_res_ready (out_free),
        .o_res       (seq_res),
        .o_ram       (ram_ctl),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

    bmhq_ram u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= seq_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && seq_res_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.removed_value = r_out.removed_value;
    assign o_res.top_value     = r_out.top_value;
    assign o_res.entry_total   = r_out.entry_total;
    assign o_res.status        = r_out.status;

    // a word never reports more entries than the heap holds
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.entry_total <= CNT_W'(CAPACITY))
        else $error("entry total above capacity");

    // a dropped push only happens on a full heap
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_FULL) |->
            (o_res.entry_total == CNT_W'(CAPACITY) && o_res.removed_value == '0))
        else $error("full status with heap not full");

    // a failed pop leaves an empty heap and removes nothing
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_EMPTY) |->
            (o_res.entry_total == '0 && o_res.removed_value == '0))
        else $error("empty status with entries present");

    // empty heap reports a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.entry_total == '0) |-> o_res.top_value == '0)
        else $error("nonzero top on empty heap");

    // one command in flight: no accept on the cycle after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while busy");

endmodule

### design/bmhq_ram.sv
module bmhq_ram import bmhq_pkg::*; (
    input  logic                     i_clk,
    input  t_ram_ctl                 i_ctl,
    output logic signed [DATA_W-1:0] o_rdata_a,
    output logic signed [DATA_W-1:0] o_rdata_b
);

    logic signed [DATA_W-1:0] mem [0:DEPTH-1];

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_ctl.waddr] <= i_ctl.wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_ctl.raddr_a];
        o_rdata_b <= mem[i_ctl.raddr_b];
    end

endmodule

### design/bmhq_cmp.sv
module bmhq_cmp import bmhq_pkg::*; (
    input  logic signed [DATA_W-1:0] i_key,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic                     i_use_b,
    output logic signed [DATA_W-1:0] o_pick,
    output logic                     o_sel_b,
    output logic                     o_key_gt
);

    // take b only when a is strictly greater; then test key > pick
    assign o_sel_b  = i_use_b && (i_a > i_b);
    assign o_pick   = o_sel_b ? i_b : i_a;
    assign o_key_gt = i_key > o_pick;

endmodule

### design/bmhq_seq.sv
module bmhq_seq import bmhq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    output logic                     o_cmd_ready,
    input  t_cmd_word                i_cmd,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res,
    output t_ram_ctl                 o_ram,
    input  logic signed [DATA_W-1:0] i_rdata_a,
    input  logic signed [DATA_W-1:0] i_rdata_b
);

    t_state r_state, n_state;

    logic [ADDR_W-1:0]        r_node;
    logic [ADDR_W:0]          r_child;
    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_last;
    logic signed [DATA_W-1:0] r_removed;
    logic signed [DATA_W-1:0] r_top;
    logic [1:0]               r_status;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     past_end;
    logic                     pushing;
    logic signed [DATA_W-1:0] cmp_key;
    logic signed [DATA_W-1:0] cmp_a;
    logic                     cmp_use_b;
    logic signed [DATA_W-1:0] cmp_pick;
    logic                     cmp_sel_b;
    logic                     cmp_key_gt;
    logic [ADDR_W-1:0]        child_lo;
    logic [ADDR_W-1:0]        sel_node;

    assign accept   = i_cmd_valid && o_cmd_ready;
    assign full     = r_count == CNT_W'(CAPACITY);
    assign empty    = r_count == '0;
    assign past_end = r_child > {1'b0, r_count};
    assign child_lo = r_child[ADDR_W-1:0];
    assign sel_node = cmp_sel_b ? child_lo + ADDR_W'(1) : child_lo;
    assign pushing  = (r_state == S_PUSH_RD) || (r_state == S_PUSH_CMP);

    // shared compare: push tests parent > value, pop tests last > smaller child
    assign cmp_key   = pushing ? i_rdata_a : r_last;
    assign cmp_a     = pushing ? r_val : i_rdata_a;
    assign cmp_use_b = !pushing && (r_child < {1'b0, r_count});

    bmhq_cmp u_cmp (
        .i_key    (cmp_key),
        .i_a      (cmp_a),
        .i_b      (i_rdata_b),
        .i_use_b  (cmp_use_b),
        .o_pick   (cmp_pick),
        .o_sel_b  (cmp_sel_b),
        .o_key_gt (cmp_key_gt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.command)
                        CMD_PUSH: n_state = full ? S_DONE : S_PUSH_RD;
                        CMD_POP:  n_state = empty ? S_DONE : S_POP_LAST;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_PUSH_RD:  n_state = (r_node == ADDR_W'(1)) ? S_DONE : S_PUSH_CMP;
            S_PUSH_CMP: n_state = cmp_key_gt ? S_PUSH_RD : S_DONE;
            S_POP_LAST: n_state = S_POP_RD;
            S_POP_RD:   n_state = past_end ? S_DONE : S_POP_CMP;
            S_POP_CMP:  n_state = cmp_key_gt ? S_POP_RD : S_DONE;
            S_DONE:     n_state = i_res_ready ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        o_cmd_ready   = 1'b0;
        o_res_valid   = 1'b0;
        o_ram.we      = 1'b0;
        o_ram.waddr   = r_node;
        o_ram.wdata   = r_val;
        o_ram.raddr_a = r_node >> 1;
        o_ram.raddr_b = child_lo + ADDR_W'(1);
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready   = 1'b1;
                o_ram.raddr_a = r_count;    // last entry, for a pop
            end
            S_PUSH_RD: begin
                o_ram.we = (r_node == ADDR_W'(1));
            end
            S_PUSH_CMP: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = cmp_key_gt ? i_rdata_a : r_val;
            end
            S_POP_RD: begin
                o_ram.we      = past_end;
                o_ram.wdata   = r_last;
                o_ram.raddr_a = child_lo;
            end
            S_POP_CMP: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = cmp_key_gt ? cmp_pick : r_last;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.removed_value = r_removed;
        o_res.top_value     = empty ? '0 : r_top;
        o_res.entry_total   = r_count;
        o_res.status        = r_status;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                unique case (i_cmd.command)
                    CMD_PUSH:  if (!full) r_count <= r_count + CNT_W'(1);
                    CMD_POP:   if (!empty) r_count <= r_count - CNT_W'(1);
                    CMD_CLEAR: r_count <= '0;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val  <= i_cmd.value;
            r_node <= r_count + ADDR_W'(1);
            if (i_cmd.command == CMD_PUSH && full) begin
                r_status <= ST_FULL;
            end else if (i_cmd.command == CMD_POP && empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
            if (i_cmd.command == CMD_POP && !empty) begin
                r_removed <= r_top;
            end else begin
                r_removed <= '0;
            end
        end
        if (r_state == S_PUSH_CMP && cmp_key_gt) begin
            r_node <= r_node >> 1;
        end
        if (r_state == S_POP_LAST) begin
            r_last  <= i_rdata_a;
            r_node  <= ADDR_W'(1);
            r_child <= (ADDR_W + 1)'(2);
        end
        if (r_state == S_POP_CMP && cmp_key_gt) begin
            r_node  <= sel_node;
            r_child <= {sel_node, 1'b0};
        end
        // shadow of the root slot
        if (o_ram.we && o_ram.waddr == ADDR_W'(1)) begin
            r_top <= o_ram.wdata;
        end
    end

endmodule
